### design/dffd_pkg.sv
package dffd_pkg;

  localparam int MANT_BITS = 96;
  localparam int MAX_SCALE = 28;
  // wide enough for 10^(MAX_SCALE-1)
  localparam int DIV_BITS  = 90;
  localparam int REM_BITS  = DIV_BITS + 1;
  localparam int RADIX     = 10;
  localparam int DIGIT_W   = 4;
  localparam int BIT_CNT_W = $clog2(MANT_BITS);
  localparam int TEN_CNT_W = $clog2(MAX_SCALE + 1);

  typedef struct packed {
    logic load;
    logic ten_step;
    logic div_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic tens_zero;
    logic bits_zero;
  } stat_t;

endpackage

### design/dffd_datapath.sv
module dffd_datapath (
  input  logic                              clk,
  input  logic [63:0]                       mantissa_low,
  input  logic [31:0]                       mantissa_high,
  input  logic [7:0]                        scale,
  input  dffd_pkg::cmd_t                    cmd,
  output dffd_pkg::stat_t                   stat,
  output logic [dffd_pkg::DIGIT_W-1:0]      digit,
  output logic                              scale_error
);
  import dffd_pkg::*;

  logic [MANT_BITS-1:0] mant;
  logic [DIV_BITS-1:0]  divisor;
  logic [DIV_BITS-1:0]  rem;
  logic [DIGIT_W-1:0]   acc;
  logic                 err;
  logic                 special;
  logic [TEN_CNT_W-1:0] tens_left;
  logic [BIT_CNT_W-1:0] bits_left;

  logic [95:0]          mant_in;
  logic [7:0]           tens_load;
  logic                 over;
  logic [REM_BITS-1:0]  rem_shift;
  logic [REM_BITS-1:0]  rem_sub;
  logic                 ge;
  logic [DIV_BITS-1:0]  rem_next;
  logic [DIV_BITS-1:0]  divisor_next;
  logic [DIGIT_W:0]     acc_dbl;
  logic [DIGIT_W:0]     acc_sub;
  logic [DIGIT_W-1:0]   acc_next;

  assign mant_in   = {mantissa_high, mantissa_low};
  assign tens_load = scale - 8'd1;
  assign over      = scale > 8'(MAX_SCALE);

  assign rem_shift = {rem, mant[MANT_BITS-1]};
  assign ge        = rem_shift >= {1'b0, divisor};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign rem_next  = ge ? rem_sub[DIV_BITS-1:0] : rem_shift[DIV_BITS-1:0];

  assign divisor_next = (divisor << 3) + (divisor << 1);

  // quotient bits arrive MSB first, so the residue mod ten is kept as they come
  assign acc_dbl  = {acc, ge};
  assign acc_sub  = acc_dbl - (DIGIT_W + 1)'(RADIX);
  assign acc_next = (acc_dbl >= (DIGIT_W + 1)'(RADIX)) ? acc_sub[DIGIT_W-1:0]
                                                        : acc_dbl[DIGIT_W-1:0];

  assign stat.special   = special;
  assign stat.tens_zero = tens_left == '0;
  assign stat.bits_zero = bits_left == '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mant      <= mant_in[MANT_BITS-1:0];
      divisor   <= DIV_BITS'(1);
      rem       <= '0;
      acc       <= '0;
      err       <= over;
      special   <= over || (scale == 8'd0);
      tens_left <= tens_load[TEN_CNT_W-1:0];
      bits_left <= BIT_CNT_W'(MANT_BITS - 1);
    end else if (cmd.ten_step) begin
      divisor   <= divisor_next;
      tens_left <= tens_left - TEN_CNT_W'(1);
    end else if (cmd.div_step) begin
      rem       <= rem_next;
      mant      <= {mant[MANT_BITS-2:0], 1'b0};
      acc       <= acc_next;
      bits_left <= bits_left - BIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      digit       <= acc;
      scale_error <= err;
    end
  end

endmodule

### design/dffd_ctrl.sv
module dffd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  dffd_pkg::stat_t stat,
  output dffd_pkg::cmd_t  cmd
);
  import dffd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_TENS   = 2'd1;
  localparam logic [1:0] S_DIVIDE = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_TENS;
        end
      end
      S_TENS: begin
        if (stat.special) begin
          state_next = S_FINISH;
        end else if (stat.tens_zero) begin
          state_next = S_DIVIDE;
        end else begin
          cmd.ten_step = 1'b1;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.bits_zero) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/decimal_first_fraction_digit.sv
// First fraction digit of a scaled decimal value mantissa / 10^scale.
// Input channel: in_valid / in_stall with mantissa_low, mantissa_high, scale
// and sign; a transaction completes when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with digit and scale_error.
// sign does not affect the digit.
// One transaction is worked on at a time. The divisor 10^(scale-1) is built
// by one times-ten step a cycle, then the restoring division runs one
// quotient bit a cycle over the whole 96-bit mantissa while the quotient
// residue mod ten is tracked. Scale 0 or above 28 skips both phases and
// yields digit 0, with scale_error set only for scale above 28.
// A new input is taken the cycle after the result is loaded into the output
// register. A stalled result stays in the output register; the next
// transaction may be accepted and processed meanwhile, and waits at its end
// until the register is free. Synchronous reset empties the output register
// and returns the controller to idle.
module decimal_first_fraction_digit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] mantissa_low,
  input  logic [31:0] mantissa_high,
  input  logic [7:0]  scale,
  input  logic        sign,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  digit,
  output logic        scale_error
);
  import dffd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dffd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dffd_datapath u_datapath (
    .clk           (clk),
    .mantissa_low  (mantissa_low),
    .mantissa_high (mantissa_high),
    .scale         (scale),
    .cmd           (cmd),
    .stat          (stat),
    .digit         (digit),
    .scale_error   (scale_error)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.ten_step, cmd.div_step, cmd.publish}))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !(out_valid && out_stall))
    else $error("waiting result overwritten");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit <= 4'd9)
    else $error("digit out of range");

  a_error_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && scale_error |-> digit == 4'd0)
    else $error("scale error with non-zero digit");

endmodule
